// ===== src/ipv4tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4tpc_pkg
// Shared types and constants of the IPv4 transport packet counter.
// ----------------------------------------------------------------------------
package ipv4tpc_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int SUM_BITS     = ((COUNTER_BITS > 16) ? COUNTER_BITS : 16) + 1;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] LINK_ETH = 2'd0;
    localparam logic [1:0] LINK_SLL = 2'd1;

    localparam logic [4:0] ETH_HDR_LEN  = 5'd14;
    localparam logic [4:0] SLL_HDR_LEN  = 5'd16;
    localparam logic [4:0] NO_HDR_LEN   = 5'd0;
    localparam logic [4:0] IPV4_MIN_LEN = 5'd20;
    localparam logic [4:0] TCP_MIN_LEN  = 5'd20;
    localparam logic [4:0] UDP_MIN_LEN  = 5'd8;
    localparam logic [3:0] IP_VERSION4  = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    localparam logic [15:0] REL_VER_LEN = 16'd0;
    localparam logic [15:0] REL_LEN_HI  = 16'd2;
    localparam logic [15:0] REL_LEN_LO  = 16'd3;
    localparam logic [15:0] REL_PROTO   = 16'd9;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] VERDICT_BAD_LINK  = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_NOT_IPV4  = 3'd2;
    localparam logic [2:0] VERDICT_TRUNCATED = 3'd3;
    localparam logic [2:0] VERDICT_TCP       = 3'd4;
    localparam logic [2:0] VERDICT_UDP       = 3'd5;
    localparam logic [2:0] VERDICT_OTHER     = 3'd6;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// ===== src/ipv4tpc_in_reg.sv =====
// ----------------------------------------------------------------------------
// ipv4tpc_in_reg
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module ipv4tpc_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ipv4tpc_pkg::item_t  s_item,
    input  logic                consume,
    output ipv4tpc_pkg::stage_t stage
);
    import ipv4tpc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready     = !valid_reg || consume;
    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/ipv4tpc_core.sv =====
// ----------------------------------------------------------------------------
// ipv4tpc_core
// Packet state, header capture, classification, counters and result register.
// ----------------------------------------------------------------------------
module ipv4tpc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipv4tpc_pkg::stage_t stage,
    output logic                consume,
    input  logic [1:0]          link_kind,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_verdict,
    output logic [31:0]         m_tcp_total,
    output logic [31:0]         m_udp_total,
    output logic [31:0]         m_bytes_total
);
    import ipv4tpc_pkg::*;

    logic [15:0]             pos_reg, pos_next;
    logic [7:0]              vl_reg, vl_next;
    logic [15:0]             tlen_reg, tlen_next;
    logic [7:0]              proto_reg, proto_next;
    logic [COUNTER_BITS-1:0] tcp_reg, tcp_next;
    logic [COUNTER_BITS-1:0] udp_reg, udp_next;
    logic [COUNTER_BITS-1:0] acc_reg, acc_next;
    logic                    out_valid_reg;
    logic [2:0]              verdict_reg, verdict_next;
    logic [31:0]             tcp_out_reg, udp_out_reg, bytes_out_reg;

    logic [4:0]          off;
    logic [15:0]         rel;
    logic [16:0]         caplen;
    logic [7:0]          vl_cur;
    logic [15:0]         tlen_cur;
    logic [7:0]          proto_cur;
    logic [SUM_BITS-1:0] sum;
    logic                is_byte;
    logic                produce;

    assign is_byte = stage.valid && (stage.item.operation == OP_BYTE);
    assign produce = is_byte && stage.item.last_byte;
    assign consume = stage.valid && (!produce || !out_valid_reg || m_ready);

    always_comb begin
        case (link_kind)
            LINK_ETH: off = ETH_HDR_LEN;
            LINK_SLL: off = SLL_HDR_LEN;
            default:  off = NO_HDR_LEN;
        endcase
    end

    assign rel    = pos_reg - 16'(off);
    assign caplen = 17'(pos_reg) + 17'd1;
    assign sum    = SUM_BITS'(acc_reg) + SUM_BITS'(stage.item.wire_length);

    always_comb begin
        vl_cur    = vl_reg;
        tlen_cur  = tlen_reg;
        proto_cur = proto_reg;
        if ((off != NO_HDR_LEN) && (pos_reg >= 16'(off))) begin
            case (rel)
                REL_VER_LEN: vl_cur = stage.item.data_byte;
                REL_LEN_HI:  tlen_cur = {stage.item.data_byte, tlen_reg[7:0]};
                REL_LEN_LO:  tlen_cur = {tlen_reg[15:8], stage.item.data_byte};
                REL_PROTO:   proto_cur = stage.item.data_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        vl_next      = vl_reg;
        tlen_next    = tlen_reg;
        proto_next   = proto_reg;
        tcp_next     = tcp_reg;
        udp_next     = udp_reg;
        acc_next     = acc_reg;
        verdict_next = VERDICT_OTHER;
        if (consume && (stage.item.operation == OP_CLEAR)) begin
            acc_next = '0;
        end else if (consume) begin
            vl_next    = vl_cur;
            tlen_next  = tlen_cur;
            proto_next = proto_cur;
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 16'd1;
            end
            if (stage.item.last_byte) begin
                if (sum > SUM_BITS'(CNT_MAX)) begin
                    acc_next = CNT_MAX;
                end else begin
                    acc_next = COUNTER_BITS'(sum);
                end
                if (off == NO_HDR_LEN) begin
                    verdict_next = VERDICT_BAD_LINK;
                end else if (caplen < 17'(off) + 17'(IPV4_MIN_LEN)) begin
                    verdict_next = VERDICT_SHORT;
                end else if ((vl_cur[7:4] != IP_VERSION4) || (vl_cur[3:0] < IHL_MIN)) begin
                    verdict_next = VERDICT_NOT_IPV4;
                end else if (caplen < 17'(off) + 17'(tlen_cur)) begin
                    verdict_next = VERDICT_TRUNCATED;
                end else if ((proto_cur == PROTO_TCP) && (tlen_cur >= 16'(TCP_MIN_LEN))) begin
                    tcp_next     = tcp_reg + 1'b1;
                    verdict_next = VERDICT_TCP;
                end else if ((proto_cur == PROTO_UDP) && (tlen_cur >= 16'(UDP_MIN_LEN))) begin
                    udp_next     = udp_reg + 1'b1;
                    verdict_next = VERDICT_UDP;
                end else begin
                    verdict_next = VERDICT_OTHER;
                end
                pos_next   = '0;
                vl_next    = '0;
                tlen_next  = '0;
                proto_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            vl_reg        <= '0;
            tlen_reg      <= '0;
            proto_reg     <= '0;
            tcp_reg       <= '0;
            udp_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            vl_reg    <= vl_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            tcp_reg   <= tcp_next;
            udp_reg   <= udp_next;
            acc_reg   <= acc_next;
            if (consume && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && produce) begin
            verdict_reg   <= verdict_next;
            tcp_out_reg   <= 32'(tcp_next);
            udp_out_reg   <= 32'(udp_next);
            bytes_out_reg <= 32'(acc_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_verdict     = verdict_reg;
    assign m_tcp_total   = tcp_out_reg;
    assign m_udp_total   = udp_out_reg;
    assign m_bytes_total = bytes_out_reg;

endmodule

// ===== src/ipv4_transport_packet_counter.sv =====
// ----------------------------------------------------------------------------
// ipv4_transport_packet_counter
// Counts TCP and UDP packets in a byte stream of captured IPv4 packets.
// ----------------------------------------------------------------------------
// One byte item is taken every cycle unless a last byte finds the result
// still untaken. Each item passes an input register and the packet state
// update; the result for a packet's last byte is written to the result
// register when the core consumes that byte and is held until taken. Only a
// last byte yields a result; a clear item zeroes the byte total, no result.
module ipv4_transport_packet_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_wire_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [31:0] m_tcp_total,
    output logic [31:0] m_udp_total,
    output logic [31:0] m_bytes_total
);
    import ipv4tpc_pkg::*;

    logic [1:0] link_kind_reg;
    item_t      s_item;
    stage_t     stage;
    logic       consume;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_kind_reg <= LINK_ETH;
        end else if (cfg_valid) begin
            link_kind_reg <= cfg_data;
        end
    end

    assign s_item.operation   = s_operation;
    assign s_item.data_byte   = s_data_byte;
    assign s_item.last_byte   = s_last_byte;
    assign s_item.wire_length = s_wire_length;

    ipv4tpc_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .consume (consume),
        .stage   (stage)
    );

    ipv4tpc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage         (stage),
        .consume       (consume),
        .link_kind     (link_kind_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_tcp_total   (m_tcp_total),
        .m_udp_total   (m_udp_total),
        .m_bytes_total (m_bytes_total)
    );

endmodule
